// ===== design/gctc_pkg.sv =====
// Shared types, constants and tables for the civil / GPS time converter.
package gctc_pkg;

  // Direction codes carried in the action field
  localparam logic ACT_TO_GPS   = 1'b0;
  localparam logic ACT_TO_CIVIL = 1'b1;

  // Microsecond spans
  localparam logic [39:0] US_PER_MIN  = 40'd60_000_000;
  localparam logic [39:0] US_PER_HOUR = 40'd3_600_000_000;
  localparam logic [39:0] US_PER_DAY  = 40'd86_400_000_000;

  // Input transaction
  typedef struct packed {
    logic        action;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [25:0] second_us;
    logic [12:0] week;
    logic [39:0] sec_of_week_us;
  } gctc_in_t;

  // Result transaction
  typedef struct packed {
    logic [11:0] res_year;
    logic [3:0]  res_month;
    logic [4:0]  res_day;
    logic [4:0]  res_hour;
    logic [5:0]  res_minute;
    logic [25:0] res_second_us;
    logic [12:0] res_week;
    logic [39:0] res_sec_of_week_us;
    logic        out_of_range;
  } gctc_out_t;

  // Normalized time: whole days since the GPS epoch plus time of day
  typedef struct packed {
    logic [15:0] day_num;
    logic [36:0] tod_us;
  } gctc_norm_t;

  // Per-transaction control that rides along the pipeline
  typedef struct packed {
    logic action;
    logic oor;
  } gctc_tag_t;

  // Civil back-end result
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [25:0] second_us;
  } gctc_civil_t;

  // GPS back-end result
  typedef struct packed {
    logic [12:0] week;
    logic [39:0] sec_of_week_us;
  } gctc_gps_t;

  // floor(30.6001 * idx), the month-length table of the Julian-day formulas
  function automatic logic [8:0] floor30(input logic [4:0] idx);
    logic [8:0] val;
    unique case (idx)
      5'd0:    val = 9'd0;
      5'd1:    val = 9'd30;
      5'd2:    val = 9'd61;
      5'd3:    val = 9'd91;
      5'd4:    val = 9'd122;
      5'd5:    val = 9'd153;
      5'd6:    val = 9'd183;
      5'd7:    val = 9'd214;
      5'd8:    val = 9'd244;
      5'd9:    val = 9'd275;
      5'd10:   val = 9'd306;
      5'd11:   val = 9'd336;
      5'd12:   val = 9'd367;
      5'd13:   val = 9'd397;
      5'd14:   val = 9'd428;
      5'd15:   val = 9'd459;
      5'd16:   val = 9'd489;
      default: val = 9'd0;
    endcase
    return val;
  endfunction

endpackage

// ===== design/gctc_front.sv =====
// Front end: turns either input form into day count plus time of day (stages 1-3).
module gctc_front import gctc_pkg::*; (
  input  logic       clk,
  input  logic [2:0] stg_en,
  input  gctc_in_t   in_data,
  output gctc_norm_t norm,
  output gctc_tag_t  tag
);

  // 1461 + 679019 + 44244: folds the year offset and MJD of the GPS epoch
  localparam logic signed [23:0] DAY_BASE_OFS = 24'sd724724;
  localparam logic signed [21:0] DAYS_LIMIT   = 22'sd43825;   // 2100-01-01
  localparam int                 SOW_DAYS_MAX = 12;

  // Stage 1: day base and raw microsecond count
  logic [12:0]        yr_adj;
  logic [4:0]         mon_idx;
  logic [22:0]        yr_days;
  logic signed [23:0] civ_base;
  logic [39:0]        civ_tod;
  logic signed [21:0] s1_base_nxt;
  logic [39:0]        s1_tod_nxt;

  logic signed [21:0] s1_base_r;
  logic [39:0]        s1_tod_r;
  logic               s1_action_r;

  always_comb begin
    // January and February count as months 13 and 14 of the year before
    if (in_data.month <= 4'd2) begin
      yr_adj  = 13'(in_data.year) + 13'd3;
      mon_idx = 5'(in_data.month) + 5'd13;
    end else begin
      yr_adj  = 13'(in_data.year) + 13'd4;
      mon_idx = 5'(in_data.month) + 5'd1;
    end
    yr_days  = (23'(yr_adj) * 23'd1461) >> 2;
    civ_base = $signed({1'b0, yr_days}) + $signed({15'd0, floor30(mon_idx)})
             + $signed({19'd0, in_data.day}) - DAY_BASE_OFS;
    civ_tod  = 40'(in_data.hour) * US_PER_HOUR + 40'(in_data.minute) * US_PER_MIN
             + 40'(in_data.second_us);

    if (in_data.action == ACT_TO_GPS) begin
      s1_base_nxt = 22'(civ_base);
      s1_tod_nxt  = civ_tod;
    end else begin
      s1_base_nxt = $signed({6'd0, 16'(in_data.week) * 16'd7});
      s1_tod_nxt  = in_data.sec_of_week_us;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[0]) begin
      s1_base_r   <= s1_base_nxt;
      s1_tod_r    <= s1_tod_nxt;
      s1_action_r <= in_data.action;
    end
  end

  // Stage 2: whole days held in the microsecond count
  logic [3:0]         s2_q_nxt;
  logic signed [21:0] s2_base_r;
  logic [39:0]        s2_tod_r;
  logic [3:0]         s2_q_r;
  logic               s2_action_r;

  always_comb begin
    s2_q_nxt = 4'd0;
    for (int k = 1; k <= SOW_DAYS_MAX; k++) begin
      if (s1_tod_r >= 40'(k) * US_PER_DAY) begin
        s2_q_nxt = s2_q_nxt + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[1]) begin
      s2_base_r   <= s1_base_r;
      s2_tod_r    <= s1_tod_r;
      s2_q_r      <= s2_q_nxt;
      s2_action_r <= s1_action_r;
    end
  end

  // Stage 3: fold the day carry in, take the remainder, range check
  logic signed [21:0] day_sum;
  logic [36:0]        rem_nxt;
  gctc_norm_t         norm_r;
  gctc_tag_t          tag_r;

  always_comb begin
    day_sum = s2_base_r + $signed({18'd0, s2_q_r});
    rem_nxt = 37'(s2_tod_r - 40'(s2_q_r) * US_PER_DAY);
  end

  always_ff @(posedge clk) begin
    if (stg_en[2]) begin
      norm_r.day_num <= day_sum[15:0];
      norm_r.tod_us  <= rem_nxt;
      tag_r.action   <= s2_action_r;
      tag_r.oor      <= (day_sum < 22'sd0) || (day_sum >= DAYS_LIMIT);
    end
  end

  assign norm = norm_r;
  assign tag  = tag_r;

endmodule

// ===== design/gctc_gps_back.sv =====
// GPS back end: day count and time of day to week and seconds of week (stages 4-6).
module gctc_gps_back import gctc_pkg::*; (
  input  logic       clk,
  input  logic [2:0] stg_en,
  input  gctc_norm_t norm,
  output gctc_gps_t  gps
);

  // ceil(2^19 / 7), exact for day counts below 2^16
  localparam logic [32:0] W_RECIP = 33'd74899;

  // Stage 4: reciprocal multiply for the week number
  logic [32:0] s4_prod_r;
  logic [15:0] s4_day_r;
  logic [36:0] s4_tod_r;

  always_ff @(posedge clk) begin
    if (stg_en[0]) begin
      s4_prod_r <= 33'(norm.day_num) * W_RECIP;
      s4_day_r  <= norm.day_num;
      s4_tod_r  <= norm.tod_us;
    end
  end

  // Stage 5: week and day of week
  logic [12:0] week_nxt;
  logic [2:0]  dow_nxt;
  logic [12:0] s5_week_r;
  logic [2:0]  s5_dow_r;
  logic [36:0] s5_tod_r;

  always_comb begin
    week_nxt = s4_prod_r[31:19];
    dow_nxt  = 3'(s4_day_r - 16'(week_nxt) * 16'd7);
  end

  always_ff @(posedge clk) begin
    if (stg_en[1]) begin
      s5_week_r <= week_nxt;
      s5_dow_r  <= dow_nxt;
      s5_tod_r  <= s4_tod_r;
    end
  end

  // Stage 6: seconds of week
  logic [12:0] s6_week_r;
  logic [39:0] s6_sow_r;

  always_ff @(posedge clk) begin
    if (stg_en[2]) begin
      s6_week_r <= s5_week_r;
      s6_sow_r  <= 40'(s5_dow_r) * US_PER_DAY + 40'(s5_tod_r);
    end
  end

  assign gps.week           = s6_week_r;
  assign gps.sec_of_week_us = s6_sow_r;

endmodule

// ===== design/gctc_civil_back.sv =====
// Civil back end: day count and time of day to calendar date and clock time (stages 4-6).
module gctc_civil_back import gctc_pkg::*; (
  input  logic        clk,
  input  logic [2:0]  stg_en,
  input  gctc_norm_t  norm,
  output gctc_civil_t civil
);

  // ceil(2^38 / 36525): year count from 100*days, exact for numerators below 2^26
  localparam logic [45:0] C_RECIP = 46'd7525747;
  // Day offset into the year-count numerator (remainder of its fixed part)
  localparam logic [22:0] C_OFS   = 23'd31115;
  // ceil(2^49 / 3515625): hours from tod >> 10
  localparam logic [54:0] H_RECIP = 55'd160127987;
  // ceil(2^42 / 234375): minutes from remainder >> 8
  localparam logic [48:0] M_RECIP = 49'd18764999;
  localparam int          E_MAX   = 16;

  // Stage 4: reciprocal multiplies for year count and hour
  logic [22:0] c_num;
  logic [45:0] s4_cprod_r;
  logic [54:0] s4_hprod_r;
  logic [15:0] s4_day_r;
  logic [36:0] s4_tod_r;

  assign c_num = 23'(norm.day_num) * 23'd100 + C_OFS;

  always_ff @(posedge clk) begin
    if (stg_en[0]) begin
      s4_cprod_r <= 46'(c_num) * C_RECIP;
      s4_hprod_r <= 55'(norm.tod_us[36:10]) * H_RECIP;
      s4_day_r   <= norm.day_num;
      s4_tod_r   <= norm.tod_us;
    end
  end

  // Stage 5: day within the shifted year, hour remainder
  logic [6:0]  cyr_nxt;
  logic [17:0] g_full;
  logic [4:0]  hour_nxt;
  logic [31:0] rem2_nxt;
  logic [6:0]  s5_cyr_r;
  logic [9:0]  s5_g_r;
  logic [4:0]  s5_hour_r;
  logic [31:0] s5_rem2_r;

  always_comb begin
    cyr_nxt  = s4_cprod_r[44:38];
    g_full   = 18'(s4_day_r) + 18'd434 - ((18'(cyr_nxt) * 18'd1461 + 18'd3) >> 2);
    hour_nxt = s4_hprod_r[53:49];
    rem2_nxt = 32'(40'(s4_tod_r) - 40'(hour_nxt) * US_PER_HOUR);
  end

  always_ff @(posedge clk) begin
    if (stg_en[1]) begin
      s5_cyr_r  <= cyr_nxt;
      s5_g_r    <= g_full[9:0];
      s5_hour_r <= hour_nxt;
      s5_rem2_r <= rem2_nxt;
    end
  end

  // Stage 6: shifted month index, minute multiply
  logic [4:0]  e_nxt;
  logic [4:0]  s6_e_r;
  logic [9:0]  s6_g_r;
  logic [6:0]  s6_cyr_r;
  logic [4:0]  s6_hour_r;
  logic [31:0] s6_rem2_r;
  logic [48:0] s6_mprod_r;

  // month index = number of table thresholds the day count lies above
  always_comb begin
    e_nxt = 5'd0;
    for (int k = 1; k <= E_MAX; k++) begin
      if (s5_g_r > 10'(floor30(5'(k)))) begin
        e_nxt = e_nxt + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[2]) begin
      s6_e_r     <= e_nxt;
      s6_g_r     <= s5_g_r;
      s6_cyr_r   <= s5_cyr_r;
      s6_hour_r  <= s5_hour_r;
      s6_rem2_r  <= s5_rem2_r;
      s6_mprod_r <= 49'(s5_rem2_r[31:8]) * M_RECIP;
    end
  end

  // Final: calendar fields, minute and seconds (registered at the output)
  logic [3:0] mon_val;
  logic [5:0] min_val;

  always_comb begin
    if (s6_e_r >= 5'd14) begin
      mon_val = 4'(s6_e_r - 5'd13);
    end else begin
      mon_val = 4'(s6_e_r - 5'd1);
    end
    min_val = s6_mprod_r[47:42];

    civil.month = mon_val;
    civil.day   = 5'(s6_g_r - 10'(floor30(s6_e_r)));
    // March onward belongs to the same year count, Jan and Feb to the next
    civil.year  = 12'd1980 + 12'(s6_cyr_r) - ((mon_val >= 4'd3) ? 12'd1 : 12'd0);
    civil.hour  = s6_hour_r;
    civil.minute    = min_val;
    civil.second_us = 26'(s6_rem2_r - 32'(min_val) * 32'(US_PER_MIN));
  end

endmodule

// ===== design/civil_gps_time_converter.sv =====
// Top level: civil date/time <-> GPS week/seconds converter, seven-stage pipeline.
// Data passes front end stages 1-3, back end stages 4-6, then the output register.
// Throughput: one transaction per cycle; each stage holds while the one after it
// is full and stalled, so empty stages still fill while the output waits.
// Reciprocal multiplies in the back ends: day/week split, year count, hour, minute.
// Reset (rst_n low, synchronous) clears the stage valid bits only; no other state.
module civil_gps_time_converter import gctc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  gctc_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output gctc_out_t out_data
);

  localparam int NUM_STG = 7;

  // Stage valid bits and per-stage enables
  logic [NUM_STG:1]   vld_r;
  logic [NUM_STG:1]   vld_nxt;
  logic [NUM_STG-1:0] vld_in;
  logic [NUM_STG+1:1] stg_en;

  always_comb begin
    stg_en[NUM_STG+1] = !out_stall;
    for (int k = NUM_STG; k >= 1; k--) begin
      stg_en[k] = !vld_r[k] || stg_en[k+1];
    end
  end

  assign vld_in = {vld_r[NUM_STG-1:1], in_valid};

  always_comb begin
    for (int k = 1; k <= NUM_STG; k++) begin
      vld_nxt[k] = stg_en[k] ? vld_in[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !stg_en[1];
  assign out_valid = vld_r[NUM_STG];

  // Datapath
  gctc_norm_t  norm;
  gctc_tag_t   tag3;
  gctc_civil_t civil;
  gctc_gps_t   gps;

  gctc_front u_front (
    .clk     (clk),
    .stg_en  (stg_en[3:1]),
    .in_data (in_data),
    .norm    (norm),
    .tag     (tag3)
  );

  gctc_gps_back u_gps_back (
    .clk    (clk),
    .stg_en (stg_en[6:4]),
    .norm   (norm),
    .gps    (gps)
  );

  gctc_civil_back u_civil_back (
    .clk    (clk),
    .stg_en (stg_en[6:4]),
    .norm   (norm),
    .civil  (civil)
  );

  // Control tag alongside the back ends
  gctc_tag_t tag4_r;
  gctc_tag_t tag5_r;
  gctc_tag_t tag6_r;

  always_ff @(posedge clk) begin
    if (stg_en[4]) begin
      tag4_r <= tag3;
    end
    if (stg_en[5]) begin
      tag5_r <= tag4_r;
    end
    if (stg_en[6]) begin
      tag6_r <= tag5_r;
    end
  end

  // Output register: pick the direction, zero everything when out of range
  gctc_out_t out_nxt;
  gctc_out_t out_data_r;

  always_comb begin
    out_nxt              = '0;
    out_nxt.out_of_range = tag6_r.oor;
    if (!tag6_r.oor) begin
      if (tag6_r.action == ACT_TO_CIVIL) begin
        out_nxt.res_year      = civil.year;
        out_nxt.res_month     = civil.month;
        out_nxt.res_day       = civil.day;
        out_nxt.res_hour      = civil.hour;
        out_nxt.res_minute    = civil.minute;
        out_nxt.res_second_us = civil.second_us;
      end else begin
        out_nxt.res_week           = gps.week;
        out_nxt.res_sec_of_week_us = gps.sec_of_week_us;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[NUM_STG]) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_data = out_data_r;

endmodule
